// ===== rtl/core/lcc_pkg.sv =====
// shared constants for the led color crossfade block
`timescale 1ns / 1ps

package lcc_pkg;

   localparam int LIGHT_COUNT_DEFAULT = 8;

   localparam int ACTION_W = 2;
   localparam int LIGHT_W = 3;
   localparam int COLOR_W = 32;
   localparam int TIME_W = 32;
   localparam int CHAN_W = 8;
   localparam int CSR_ADDR_W = 2;

   localparam logic [ACTION_W-1:0] ACT_WRITE_START = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_WRITE_END = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_RENDER = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] REG_START_TIME = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_DURATION = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_MODE = 2'd2;

   localparam logic MODE_LINEAR = 1'b0;
   localparam logic MODE_SMOOTH = 1'b1;

   // fade progress fraction bits and smoothstep scale
   localparam int FRAC_W = 16;
   localparam int SMOOTH_SHIFT = 48;
   localparam int SPLIT_W = 24;

endpackage

// ===== rtl/core/led_color_crossfade.sv =====
// top level of the rgbw color crossfade block with iterative divide and blend
`timescale 1ns / 1ps

// Keeps a start and an end RGBW color per light and renders the blended color of one
// light at a given time. A write item updates its table as it is taken. A render item
// outside the fade window goes through the check and finish states to the output
// register; inside the window it runs a radix-2 restoring divider for the 16-bit
// progress fraction and then one shared signed multiplier over the four channels,
// with square and cube passes ahead of the channel products in smoothstep mode. A
// finished result waits in the output register while the next item is taken. Both
// color tables read as black after reset through per-entry valid bits, so no
// clearing pass is needed.
module led_color_crossfade #(
   parameter int LIGHT_COUNT = lcc_pkg::LIGHT_COUNT_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [lcc_pkg::ACTION_W-1:0]       req_action,
   input  logic [lcc_pkg::LIGHT_W-1:0]        req_light_index,
   input  logic [lcc_pkg::COLOR_W-1:0]        req_color_value,
   input  logic [lcc_pkg::TIME_W-1:0]         req_now,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [lcc_pkg::LIGHT_W-1:0]        rsp_out_light,
   output logic [lcc_pkg::CHAN_W-1:0]         rsp_red,
   output logic [lcc_pkg::CHAN_W-1:0]         rsp_green,
   output logic [lcc_pkg::CHAN_W-1:0]         rsp_blue,
   output logic [lcc_pkg::CHAN_W-1:0]         rsp_white,
   output logic                               rsp_before_start,
   input  logic                               csr_wr_en,
   input  logic [lcc_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [lcc_pkg::TIME_W-1:0]         csr_wr_data
);

   localparam int IDX_W = (LIGHT_COUNT > 1) ? $clog2(LIGHT_COUNT) : 1;
   localparam int FRAC_W = lcc_pkg::FRAC_W;
   localparam int CNT_W = $clog2(FRAC_W);
   localparam int MA_W = 33;
   localparam int MB_W = 19;
   localparam int PROD_W = MA_W + MB_W;
   localparam int S_W = lcc_pkg::SMOOTH_SHIFT + 1;
   localparam int SPLIT_W = lcc_pkg::SPLIT_W;
   localparam int ACC_W = 58;
   localparam int TIME_W = lcc_pkg::TIME_W;
   localparam int COLOR_W = lcc_pkg::COLOR_W;
   localparam int SUM_SH_W = 10;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_CHECK = 4'd1;
   localparam logic [3:0] ST_DIV = 4'd2;
   localparam logic [3:0] ST_SQ = 4'd3;
   localparam logic [3:0] ST_CUBE = 4'd4;
   localparam logic [3:0] ST_CH_HI = 4'd5;
   localparam logic [3:0] ST_CH_LO = 4'd6;
   localparam logic [3:0] ST_CH_ADD = 4'd7;
   localparam logic [3:0] ST_FIN = 4'd8;

   // color tables
   logic [COLOR_W-1:0] start_mem [LIGHT_COUNT];
   logic [COLOR_W-1:0] end_mem [LIGHT_COUNT];
   logic [LIGHT_COUNT-1:0] start_vld_ff, start_vld_in;
   logic [LIGHT_COUNT-1:0] end_vld_ff, end_vld_in;
   logic [COLOR_W-1:0] rd_start_ff, rd_end_ff;
   logic rd_start_ok_ff, rd_end_ok_ff;

   // control
   logic [3:0] state_ff, state_in;
   logic [1:0] ch_ff, ch_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // configuration
   logic [TIME_W-1:0] start_time_ff, start_time_in;
   logic [TIME_W-1:0] duration_ff, duration_in;
   logic mode_ff, mode_in;

   // datapath
   logic [lcc_pkg::LIGHT_W-1:0] light_ff, light_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [TIME_W-1:0] end_ff, end_in;
   logic [TIME_W-1:0] rem_ff, rem_in;
   logic [FRAC_W-1:0] quo_ff, quo_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [S_W-1:0] s_ff, s_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [COLOR_W-1:0] res_ff, res_in;
   logic flag_ff, flag_in;

   // output register
   logic rsp_valid_ff, rsp_valid_in;
   logic [lcc_pkg::LIGHT_W-1:0] rsp_light_ff, rsp_light_in;
   logic [COLOR_W-1:0] rsp_color_ff, rsp_color_in;
   logic rsp_flag_ff, rsp_flag_in;

   logic req_acc;
   logic in_range;
   logic [IDX_W-1:0] req_idx;
   logic wr_start_en, wr_end_en, rd_en;
   logic [COLOR_W-1:0] a_col, b_col;
   logic [lcc_pkg::CHAN_W-1:0] c0, c1;
   logic signed [8:0] diff;
   logic signed [MA_W-1:0] mul_a;
   logic signed [MB_W-1:0] mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic [TIME_W:0] rem2;
   logic div_ge;
   logic signed [ACC_W-1:0] sum;
   logic signed [SUM_SH_W-1:0] sum_sh;
   logic [SUM_SH_W-1:0] chan_val;
   logic out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc = req_valid && !req_stall;
   assign in_range = (32'(req_light_index) < LIGHT_COUNT);
   assign req_idx = IDX_W'(req_light_index);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign a_col = rd_start_ok_ff ? rd_start_ff : '0;
   assign b_col = rd_end_ok_ff ? rd_end_ff : '0;
   assign c0 = a_col[{ch_ff, 3'b000} +: lcc_pkg::CHAN_W];
   assign c1 = b_col[{ch_ff, 3'b000} +: lcc_pkg::CHAN_W];
   assign diff = $signed({1'b0, c1}) - $signed({1'b0, c0});

   assign rem2 = {rem_ff, 1'b0};
   assign div_ge = (rem2 >= {1'b0, duration_ff});

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_SQ: begin
            mul_a = $signed(MA_W'(quo_ff));
            mul_b = $signed(MB_W'(quo_ff));
         end
         ST_CUBE: begin
            mul_a = $signed({1'b0, prod_ff[31:0]});
            mul_b = $signed(MB_W'(3 << FRAC_W) - MB_W'({quo_ff, 1'b0}));
         end
         ST_CH_HI: begin
            mul_a = $signed(MA_W'(s_ff[S_W-1:SPLIT_W]));
            mul_b = MB_W'(diff);
         end
         ST_CH_LO: begin
            mul_a = (mode_ff == lcc_pkg::MODE_SMOOTH) ? $signed(MA_W'(s_ff[SPLIT_W-1:0]))
                                                     : $signed(MA_W'(quo_ff));
            mul_b = MB_W'(diff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   assign sum = acc_ff + ACC_W'(prod_ff);
   assign sum_sh = (mode_ff == lcc_pkg::MODE_SMOOTH)
                   ? sum[lcc_pkg::SMOOTH_SHIFT +: SUM_SH_W]
                   : sum[FRAC_W +: SUM_SH_W];
   assign chan_val = SUM_SH_W'(c0) + SUM_SH_W'(sum_sh);

   // accept decode
   always_comb begin
      wr_start_en = 1'b0;
      wr_end_en = 1'b0;
      rd_en = 1'b0;
      if (req_acc && in_range) begin
         unique case (req_action)
            lcc_pkg::ACT_WRITE_START: wr_start_en = 1'b1;
            lcc_pkg::ACT_WRITE_END: wr_end_en = 1'b1;
            lcc_pkg::ACT_RENDER: rd_en = 1'b1;
            default: rd_en = 1'b0;
         endcase
      end
   end

   always_comb begin
      start_vld_in = start_vld_ff;
      end_vld_in = end_vld_ff;
      if (wr_start_en) begin
         start_vld_in[req_idx] = 1'b1;
      end
      if (wr_end_en) begin
         end_vld_in[req_idx] = 1'b1;
      end
   end

   always_comb begin
      start_time_in = start_time_ff;
      duration_in = duration_ff;
      mode_in = mode_ff;
      if (csr_wr_en) begin
         unique case (csr_addr)
            lcc_pkg::REG_START_TIME: start_time_in = csr_wr_data;
            lcc_pkg::REG_DURATION: duration_in = csr_wr_data;
            lcc_pkg::REG_MODE: mode_in = csr_wr_data[0];
            default: mode_in = mode_ff;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      ch_in = ch_ff;
      cnt_in = cnt_ff;
      light_in = light_ff;
      now_in = now_ff;
      end_in = end_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      prod_in = prod_ff;
      s_in = s_ff;
      acc_in = acc_ff;
      res_in = res_ff;
      flag_in = flag_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_light_in = rsp_light_ff;
      rsp_color_in = rsp_color_ff;
      rsp_flag_in = rsp_flag_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (rd_en) begin
               light_in = req_light_index;
               now_in = req_now;
               end_in = start_time_ff + duration_ff;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            res_in = '0;
            if (now_ff >= end_ff) begin
               res_in = b_col;
               flag_in = 1'b0;
               state_in = ST_FIN;
            end else if (now_ff < start_time_ff) begin
               res_in = a_col;
               flag_in = 1'b1;
               state_in = ST_FIN;
            end else begin
               rem_in = now_ff - start_time_ff;
               quo_in = '0;
               cnt_in = '0;
               flag_in = 1'b0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = div_ge ? TIME_W'(rem2 - {1'b0, duration_ff}) : rem2[TIME_W-1:0];
            quo_in = {quo_ff[FRAC_W-2:0], div_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(FRAC_W - 1)) begin
               ch_in = '0;
               state_in = (mode_ff == lcc_pkg::MODE_SMOOTH) ? ST_SQ : ST_CH_LO;
            end
         end
         ST_SQ: begin
            prod_in = mul_p;
            state_in = ST_CUBE;
         end
         ST_CUBE: begin
            s_in = mul_p[S_W-1:0];
            state_in = ST_CH_HI;
         end
         ST_CH_HI: begin
            prod_in = mul_p;
            state_in = ST_CH_LO;
         end
         ST_CH_LO: begin
            if (mode_ff == lcc_pkg::MODE_SMOOTH) begin
               acc_in = (ACC_W'(prod_ff) <<< SPLIT_W)
                        + (ACC_W'(1) <<< (lcc_pkg::SMOOTH_SHIFT - 1));
            end else begin
               acc_in = '0;
            end
            prod_in = mul_p;
            state_in = ST_CH_ADD;
         end
         ST_CH_ADD: begin
            res_in[{ch_ff, 3'b000} +: lcc_pkg::CHAN_W] = chan_val[lcc_pkg::CHAN_W-1:0];
            ch_in = ch_ff + 1'b1;
            if (ch_ff == 2'd3) begin
               state_in = ST_FIN;
            end else begin
               state_in = (mode_ff == lcc_pkg::MODE_SMOOTH) ? ST_CH_HI : ST_CH_LO;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_light_in = light_ff;
               rsp_color_in = res_ff;
               rsp_flag_in = flag_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         start_vld_ff <= '0;
         end_vld_ff <= '0;
         start_time_ff <= '0;
         duration_ff <= '0;
         mode_ff <= lcc_pkg::MODE_LINEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_vld_ff <= start_vld_in;
         end_vld_ff <= end_vld_in;
         start_time_ff <= start_time_in;
         duration_ff <= duration_in;
         mode_ff <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff <= ch_in;
      cnt_ff <= cnt_in;
      light_ff <= light_in;
      now_ff <= now_in;
      end_ff <= end_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      prod_ff <= prod_in;
      s_ff <= s_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
      flag_ff <= flag_in;
      rsp_light_ff <= rsp_light_in;
      rsp_color_ff <= rsp_color_in;
      rsp_flag_ff <= rsp_flag_in;
   end

   // table write and registered read
   always_ff @(posedge clock) begin
      if (wr_start_en) begin
         start_mem[req_idx] <= req_color_value;
      end
      if (wr_end_en) begin
         end_mem[req_idx] <= req_color_value;
      end
      if (rd_en) begin
         rd_start_ff <= start_mem[req_idx];
         rd_end_ff <= end_mem[req_idx];
         rd_start_ok_ff <= start_vld_ff[req_idx];
         rd_end_ok_ff <= end_vld_ff[req_idx];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_light = rsp_light_ff;
   assign rsp_white = rsp_color_ff[31:24];
   assign rsp_green = rsp_color_ff[23:16];
   assign rsp_red = rsp_color_ff[15:8];
   assign rsp_blue = rsp_color_ff[7:0];
   assign rsp_before_start = rsp_flag_ff;

endmodule

// ===== tb/tb_led_color_crossfade.sv =====
// self-checking testbench for the led color crossfade block
`timescale 1ns / 1ps

module tb_led_color_crossfade;

   localparam int ACTION_W = lcc_pkg::ACTION_W;
   localparam int LIGHT_W = lcc_pkg::LIGHT_W;
   localparam int COLOR_W = lcc_pkg::COLOR_W;
   localparam int TIME_W = lcc_pkg::TIME_W;
   localparam int CHAN_W = lcc_pkg::CHAN_W;
   localparam int CSR_ADDR_W = lcc_pkg::CSR_ADDR_W;
   localparam int FRAC_W = lcc_pkg::FRAC_W;

   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_UNUSED = 2'd3;
   localparam int LIGHTS = lcc_pkg::LIGHT_COUNT_DEFAULT;
   localparam int SETTLE_CYCLES = 48;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASES = 9;
   localparam int PHASE_ITEMS = 100;

   typedef struct packed {
      logic [LIGHT_W-1:0] light;
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
      logic [CHAN_W-1:0]  white;
      logic               before_start;
   } shade_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [LIGHT_W-1:0]  light;
      logic [COLOR_W-1:0]  color;
      logic [TIME_W-1:0]   now;
   } lamp_item_type;

   typedef struct {
      bit                retime;
      logic [TIME_W-1:0] t0;
      logic [TIME_W-1:0] len;
      logic              mode;
      lamp_item_type     item;
      bit                known;
      shade_type         want;
   } script_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [ACTION_W-1:0]   req_action = '0;
   logic [LIGHT_W-1:0]    req_light_index = '0;
   logic [COLOR_W-1:0]    req_color_value = '0;
   logic [TIME_W-1:0]     req_now = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [LIGHT_W-1:0]    rsp_out_light;
   logic [CHAN_W-1:0]     rsp_red;
   logic [CHAN_W-1:0]     rsp_green;
   logic [CHAN_W-1:0]     rsp_blue;
   logic [CHAN_W-1:0]     rsp_white;
   logic                  rsp_before_start;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [TIME_W-1:0]     csr_wr_data = '0;

   // fade settings and color tables as the block should hold them
   logic [COLOR_W-1:0] from_color [LIGHTS];
   logic [COLOR_W-1:0] to_color [LIGHTS];
   logic [TIME_W-1:0]  fade_start = '0;
   logic [TIME_W-1:0]  fade_len = '0;
   logic               fade_mode = lcc_pkg::MODE_LINEAR;

   shade_type shades_due [$];
   int        mismatch_count = 0;
   int        quiet_cycles = 0;
   bit        calm = 1'b0;
   bit        bursty = 1'b1;

   led_color_crossfade dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_light_index (req_light_index),
      .req_color_value (req_color_value),
      .req_now         (req_now),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_light   (rsp_out_light),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_white       (rsp_white),
      .rsp_before_start(rsp_before_start),
      .csr_wr_en       (csr_wr_en),
      .csr_addr        (csr_addr),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic shade_type unpack_color(input logic [LIGHT_W-1:0] light,
                                              input logic [COLOR_W-1:0] color,
                                              input logic flag);
      shade_type s;
      s.light = light;
      s.white = color[31:24];
      s.green = color[23:16];
      s.red = color[15:8];
      s.blue = color[7:0];
      s.before_start = flag;
      return s;
   endfunction

   function automatic logic [CHAN_W-1:0] mix_channel(input logic [CHAN_W-1:0] c0,
                                                     input logic [CHAN_W-1:0] c1,
                                                     input logic [FRAC_W-1:0] frac);
      logic [63:0] a, b, p, curve, acc;
      a = {56'd0, c0};
      b = {56'd0, c1};
      p = {48'd0, frac};
      if (fade_mode == lcc_pkg::MODE_LINEAR) begin
         acc = a * (64'd65536 - p) + b * p;
         return acc[23:16];
      end
      // smoothstep curve scaled by 2^48, rounded half up
      curve = p * p * (64'd196608 - 64'd2 * p);
      acc = a * ((64'd1 << 48) - curve) + b * curve + (64'd1 << 47);
      return acc[55:48];
   endfunction

   function automatic shade_type blend_light(input logic [LIGHT_W-1:0] light,
                                             input logic [TIME_W-1:0] now);
      logic [COLOR_W-1:0] c_from, c_to;
      logic [TIME_W-1:0]  fade_end, diff, width;
      logic [63:0]        quot;
      shade_type          s;
      c_from = from_color[light];
      c_to = to_color[light];
      fade_end = fade_start + fade_len;
      if (now >= fade_end) return unpack_color(light, c_to, 1'b0);
      if (now < fade_start) return unpack_color(light, c_from, 1'b1);
      diff = now - fade_start;
      width = fade_end - fade_start;
      quot = ({32'd0, diff} << 16) / {32'd0, width};
      s.light = light;
      s.before_start = 1'b0;
      s.red = mix_channel(c_from[15:8], c_to[15:8], quot[15:0]);
      s.green = mix_channel(c_from[23:16], c_to[23:16], quot[15:0]);
      s.blue = mix_channel(c_from[7:0], c_to[7:0], quot[15:0]);
      s.white = mix_channel(c_from[31:24], c_to[31:24], quot[15:0]);
      return s;
   endfunction

   function automatic script_row_type item_row(input logic [ACTION_W-1:0] action,
                                               input logic [LIGHT_W-1:0] light,
                                               input logic [COLOR_W-1:0] color,
                                               input logic [TIME_W-1:0] now,
                                               input bit known, input shade_type want);
      script_row_type r;
      r.retime = 1'b0;
      r.t0 = '0;
      r.len = '0;
      r.mode = lcc_pkg::MODE_LINEAR;
      r.item.action = action;
      r.item.light = light;
      r.item.color = color;
      r.item.now = now;
      r.known = known;
      r.want = want;
      return r;
   endfunction

   function automatic script_row_type fade_row(input logic [TIME_W-1:0] t0,
                                               input logic [TIME_W-1:0] len,
                                               input logic mode);
      script_row_type r;
      r.retime = 1'b1;
      r.t0 = t0;
      r.len = len;
      r.mode = mode;
      r.item = '0;
      r.known = 1'b0;
      r.want = '0;
      return r;
   endfunction

   task automatic send_item(input lamp_item_type it, input bit known, input shade_type want);
      req_valid <= 1'b1;
      req_action <= it.action;
      req_light_index <= it.light;
      req_color_value <= it.color;
      req_now <= it.now;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      case (it.action)
         lcc_pkg::ACT_WRITE_START: from_color[it.light] = it.color;
         lcc_pkg::ACT_WRITE_END: to_color[it.light] = it.color;
         lcc_pkg::ACT_RENDER: shades_due.push_back(known ? want : blend_light(it.light, it.now));
         default: ;
      endcase
   endtask

   task automatic maybe_pause();
      if ($urandom_range(0, 39) == 0) bursty = !bursty;
      if (!calm && bursty && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (shades_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [TIME_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_addr <= addr;
      csr_wr_data <= data;
      @(posedge clock);
   endtask

   task automatic program_fade(input logic [TIME_W-1:0] t0, input logic [TIME_W-1:0] len,
                               input logic mode);
      logic [TIME_W-1:0] filler;
      filler = $urandom;
      wait_for_drain();
      write_csr(lcc_pkg::REG_START_TIME, t0);
      write_csr(lcc_pkg::REG_DURATION, len);
      write_csr(lcc_pkg::REG_MODE, {filler[TIME_W-2:0], mode});
      write_csr(REG_UNUSED, $urandom);
      csr_wr_en <= 1'b0;
      fade_start = t0;
      fade_len = len;
      fade_mode = mode;
   endtask

   initial begin
      script_row_type    script [$];
      lamp_item_type     it;
      logic [TIME_W-1:0] t0, len;
      int                pick;

      foreach (from_color[i]) begin
         from_color[i] = '0;
         to_color[i] = '0;
      end

      // reset state: zero length fade over black tables
      script.push_back(item_row(lcc_pkg::ACT_RENDER, 3'd0, '0, '0, 1'b1,
                                unpack_color(3'd0, '0, 1'b0)));
      script.push_back(item_row(lcc_pkg::ACT_RENDER, 3'd7, '0, '1, 1'b1,
                                unpack_color(3'd7, '0, 1'b0)));
      script.push_back(item_row(lcc_pkg::ACT_WRITE_START, 3'd7, '1, '0, 1'b0, '0));
      script.push_back(item_row(lcc_pkg::ACT_WRITE_END, 3'd7, '0, '0, 1'b0, '0));
      script.push_back(item_row(lcc_pkg::ACT_WRITE_START, 3'd0, '0, '1, 1'b0, '0));
      script.push_back(item_row(lcc_pkg::ACT_WRITE_END, 3'd0, '1, '0, 1'b0, '0));
      script.push_back(item_row(lcc_pkg::ACT_WRITE_END, 3'd3, 32'hA0B0_C0D0, '0, 1'b0, '0));
      script.push_back(item_row(lcc_pkg::ACT_RENDER, 3'd3, '0, 32'd12345, 1'b1,
                                unpack_color(3'd3, 32'hA0B0_C0D0, 1'b0)));
      // unused action must leave the table alone
      script.push_back(item_row(ACT_UNUSED, 3'd3, 32'h1234_5678, '0, 1'b0, '0));
      script.push_back(item_row(lcc_pkg::ACT_RENDER, 3'd3, 32'h1234_5678, '0, 1'b1,
                                unpack_color(3'd3, 32'hA0B0_C0D0, 1'b0)));
      script.push_back(item_row(lcc_pkg::ACT_RENDER, 3'd0, '0, '0, 1'b1,
                                unpack_color(3'd0, '1, 1'b0)));
      script.push_back(fade_row(32'd1000, 32'd65536, lcc_pkg::MODE_LINEAR));
      script.push_back(item_row(lcc_pkg::ACT_RENDER, 3'd0, '0, 32'd999, 1'b1,
                                unpack_color(3'd0, '0, 1'b1)));
      script.push_back(item_row(lcc_pkg::ACT_RENDER, 3'd0, '0, 32'd1000, 1'b1,
                                unpack_color(3'd0, '0, 1'b0)));
      script.push_back(item_row(lcc_pkg::ACT_RENDER, 3'd0, '0, 32'd33768, 1'b0, '0));
      script.push_back(item_row(lcc_pkg::ACT_RENDER, 3'd0, '0, 32'd66535, 1'b0, '0));
      script.push_back(item_row(lcc_pkg::ACT_RENDER, 3'd0, '0, 32'd66536, 1'b1,
                                unpack_color(3'd0, '1, 1'b0)));
      script.push_back(item_row(lcc_pkg::ACT_RENDER, 3'd7, '0, 32'd1500, 1'b0, '0));
      script.push_back(fade_row(32'd1000, 32'd65536, lcc_pkg::MODE_SMOOTH));
      script.push_back(item_row(lcc_pkg::ACT_RENDER, 3'd0, '0, 32'd33768, 1'b0, '0));
      script.push_back(item_row(lcc_pkg::ACT_RENDER, 3'd7, '0, 32'd66535, 1'b0, '0));
      script.push_back(item_row(lcc_pkg::ACT_RENDER, 3'd0, '0, 32'd1000, 1'b1,
                                unpack_color(3'd0, '0, 1'b0)));
      // end time wraps below start time
      script.push_back(fade_row(32'hFFFF_FF00, 32'h200, lcc_pkg::MODE_LINEAR));
      script.push_back(item_row(lcc_pkg::ACT_RENDER, 3'd0, '0, 32'hFFFF_FF80, 1'b1,
                                unpack_color(3'd0, '1, 1'b0)));
      script.push_back(item_row(lcc_pkg::ACT_RENDER, 3'd0, '0, 32'h80, 1'b1,
                                unpack_color(3'd0, '0, 1'b1)));
      script.push_back(fade_row('1, '1, lcc_pkg::MODE_SMOOTH));
      script.push_back(item_row(lcc_pkg::ACT_RENDER, 3'd3, '0, '1, 1'b1,
                                unpack_color(3'd3, 32'hA0B0_C0D0, 1'b0)));
      script.push_back(item_row(lcc_pkg::ACT_RENDER, 3'd7, '0, 32'd5, 1'b1,
                                unpack_color(3'd7, '1, 1'b1)));
      script.push_back(fade_row('0, '1, lcc_pkg::MODE_LINEAR));
      script.push_back(item_row(lcc_pkg::ACT_RENDER, 3'd0, '0, 32'h8000_0000, 1'b0, '0));
      script.push_back(item_row(lcc_pkg::ACT_RENDER, 3'd7, '0, 32'hFFFF_FFFE, 1'b0, '0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].retime) begin
            program_fade(script[i].t0, script[i].len, script[i].mode);
         end else begin
            send_item(script[i].item, script[i].known, script[i].want);
            maybe_pause();
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin
               t0 = '0;
               len = '1;
            end
            1: begin
               t0 = 32'hFFFF_FF00;
               len = 32'hFF;
            end
            2: begin
               t0 = $urandom;
               len = '0;
            end
            3: begin
               t0 = $urandom;
               len = 32'd1;
            end
            default: begin
               t0 = $urandom;
               case ($urandom_range(0, 2))
                  0: len = $urandom_range(2, 300);
                  1: len = $urandom_range(301, 32'h0010_0000);
                  default: len = $urandom;
               endcase
            end
         endcase
         if (ph == PHASES - 1) calm = 1'b1;
         program_fade(t0, len, ph[0] ? lcc_pkg::MODE_SMOOTH : lcc_pkg::MODE_LINEAR);

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) it.action = ACT_UNUSED;
            else if (pick <= 5) it.action = lcc_pkg::ACT_WRITE_START;
            else if (pick <= 9) it.action = lcc_pkg::ACT_WRITE_END;
            else it.action = lcc_pkg::ACT_RENDER;
            it.light = LIGHT_W'($urandom_range(0, LIGHTS - 1));
            if ($urandom_range(0, 7) == 0)
               it.color = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            else
               it.color = $urandom;
            case ($urandom_range(0, 9))
               0: it.now = $urandom;
               1: it.now = t0 - $urandom_range(1, 1000);
               2: it.now = t0 + len + $urandom_range(0, 1000);
               3: it.now = t0 + len - 1;
               4: it.now = t0;
               default: it.now = t0 + ((len == 0) ? 32'd0 : $urandom_range(0, len - 1));
            endcase
            send_item(it, 1'b0, '0);
            maybe_pause();
         end
      end

      wait_for_drain();
      if (mismatch_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   // result side backpressure
   initial begin
      forever begin
         @(posedge clock);
         if (!calm) begin
            case ($urandom_range(0, 11))
               0: begin
                  rsp_stall <= 1'b1;
                  repeat ($urandom_range(1, 15)) @(posedge clock);
                  rsp_stall <= 1'b0;
               end
               1: repeat ($urandom_range(20, 80)) @(posedge clock);
               default: ;
            endcase
         end
      end
   end

   task automatic note_mismatch(input string what, input shade_type want,
                                input shade_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display({"%s: want light %0d r %h g %h b %h w %h pre %b,",
                   " got light %0d r %h g %h b %h w %h pre %b"},
                  what, want.light, want.red, want.green, want.blue, want.white,
                  want.before_start, got.light, got.red, got.green, got.blue, got.white,
                  got.before_start);
   endtask

   always @(posedge clock) begin
      shade_type got, want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         got.light = rsp_out_light;
         got.red = rsp_red;
         got.green = rsp_green;
         got.blue = rsp_blue;
         got.white = rsp_white;
         got.before_start = rsp_before_start;
         if (shades_due.size() == 0) begin
            note_mismatch("unexpected item", '0, got);
         end else begin
            want = shades_due.pop_front();
            if (got.light !== want.light || got.red !== want.red ||
                got.green !== want.green || got.blue !== want.blue ||
                got.white !== want.white || got.before_start !== want.before_start)
               note_mismatch("wrong color", want, got);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_valid && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
